[rtl/hci_pkg.sv]
// Package for the HSV colour interpolator: shared types and constants.
package hci_pkg;

   localparam int CH_W = 8;
   localparam int BLEND_W = 9;
   localparam int H6_W = 11;
   localparam logic [BLEND_W-1:0] BLEND_ONE = 9'd256;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;

   typedef struct packed {
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] d;
      logic [H6_W-1:0] h6;
   } hci_color_type;

   typedef struct packed {
      hci_color_type color_a;
      hci_color_type color_b;
      logic [BLEND_W-1:0] t;
   } hci_item_type;

   typedef struct packed {
      logic valid;
      hci_item_type item;
   } hci_qport_type;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } hci_sector_type;

endpackage

[rtl/hci_front.sv]
// Front end: per-colour max, delta and hue sixth, blend amount saturation.
module hci_front (
   input  logic [7:0] from_red,
   input  logic [7:0] from_green,
   input  logic [7:0] from_blue,
   input  logic [7:0] to_red,
   input  logic [7:0] to_green,
   input  logic [7:0] to_blue,
   input  logic [8:0] blend_amount,
   output hci_pkg::hci_item_type item
);

   function automatic hci_pkg::hci_color_type classify(input logic [7:0] r,
                                                        input logic [7:0] g,
                                                        input logic [7:0] b);
      hci_pkg::hci_color_type c;
      logic [7:0] mx;
      logic [7:0] mn;
      logic [10:0] d6;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c.mx = mx;
      c.d = mx - mn;
      d6 = 11'(c.d) * 11'd6;
      if (mx == r) begin
         if (g >= b) begin
            c.h6 = 11'(g) - 11'(b);
         end else begin
            c.h6 = d6 - (11'(b) - 11'(g));
         end
      end else if (mx == g) begin
         c.h6 = (11'(c.d) << 1) + 11'(b) - 11'(r);
      end else begin
         c.h6 = (11'(c.d) << 2) + 11'(r) - 11'(g);
      end
      return c;
   endfunction

   always_comb begin
      item.color_a = classify(from_red, from_green, from_blue);
      item.color_b = classify(to_red, to_green, to_blue);
      item.t = (blend_amount > hci_pkg::BLEND_ONE) ? hci_pkg::BLEND_ONE : blend_amount;
   end

endmodule

[rtl/hci_queue.sv]
// Two-entry queue decoupling the front end from the arithmetic back end.
module hci_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hci_pkg::hci_item_type  wr_item,
   output logic                   full,
   input  logic                   pop,
   output hci_pkg::hci_qport_type rd_port
);

   hci_pkg::hci_item_type mem_ff [hci_pkg::QDEPTH];
   logic [hci_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hci_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hci_pkg::QPTR_W:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == (hci_pkg::QPTR_W+1)'(hci_pkg::QDEPTH));
   assign do_push = push && !full;
   assign do_pop = pop && (cnt_ff != '0);
   assign rd_port.valid = (cnt_ff != '0);
   assign rd_port.item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= wr_item;
   end

endmodule

[rtl/hci_back.sv]
// Back end: wraps the arithmetic pipeline behind the queue and the result handshake.
module hci_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hci_pkg::hci_qport_type q_port,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue
);

   hci_back_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .q_port        (q_port),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule

[rtl/hci_back_core.sv]
// Back end arithmetic pipeline: dividers, blend, HSV to RGB, result register.
module hci_back_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hci_pkg::hci_qport_type q_port,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue
);

   localparam int F = FRAC_BITS;
   localparam int NST = F + 1;
   localparam int RWS = F + 9;
   localparam int RWH = F + 12;
   localparam longint One = longint'(1) << F;
   localparam logic [F:0] ONE_Q = (F+1)'(One);
   localparam logic [2*F+1:0] HALF_P = (2*F+2)'(One >> 1);
   localparam logic signed [F+1:0] ONE_S = (F+2)'(One);
   localparam logic signed [F+1:0] HALF_S = (F+2)'(One >> 1);

   typedef struct packed {
      logic [RWS-1:0] rem_sa;
      logic [RWS-1:0] rem_sb;
      logic [F:0]     quo_sa;
      logic [F:0]     quo_sb;
      logic [RWH-1:0] rem_ha;
      logic [RWH-1:0] rem_hb;
      logic [F:0]     quo_ha;
      logic [F:0]     quo_hb;
      logic [7:0]     mx_a;
      logic [7:0]     mx_b;
      logic [7:0]     d_a;
      logic [7:0]     d_b;
      logic [8:0]     t;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type p, input int b);
      div_stage_type n;
      logic [RWS-1:0] ss_a, ss_b;
      logic [RWH-1:0] sh_a, sh_b;
      n = p;
      ss_a = RWS'(p.mx_a) << b;
      ss_b = RWS'(p.mx_b) << b;
      sh_a = (RWH'(p.d_a) * RWH'(6)) << b;
      sh_b = (RWH'(p.d_b) * RWH'(6)) << b;
      if (p.rem_sa >= ss_a) begin
         n.rem_sa = p.rem_sa - ss_a;
         n.quo_sa[b] = 1'b1;
      end
      if (p.rem_sb >= ss_b) begin
         n.rem_sb = p.rem_sb - ss_b;
         n.quo_sb[b] = 1'b1;
      end
      if (p.rem_ha >= sh_a) begin
         n.rem_ha = p.rem_ha - sh_a;
         n.quo_ha[b] = 1'b1;
      end
      if (p.rem_hb >= sh_b) begin
         n.rem_hb = p.rem_hb - sh_b;
         n.quo_hb[b] = 1'b1;
      end
      return n;
   endfunction

   function automatic logic [F:0] rnd_mul(input logic [F:0] a, input logic [F:0] b);
      logic [2*F+1:0] pr;
      pr = (2*F+2)'(a) * (2*F+2)'(b) + HALF_P;
      return pr[2*F:F];
   endfunction

   function automatic logic [7:0] to_byte(input logic [F:0] c);
      logic [F:0] cc;
      logic [F+8:0] y;
      cc = (c > ONE_Q) ? ONE_Q : c;
      y = ((F+9)'(cc) << 8) - (F+9)'(cc) + (F+9)'(One >> 1);
      return y[F+7:F];
   endfunction

   // value lookup: round(mx * 2^F / 255)
   logic [F:0] vtab [256];
   for (genvar k = 0; k < 256; k++) begin : g_vtab
      assign vtab[k] = (F+1)'((longint'(k) * One + 127) / 255);
   end

   logic adv;
   logic out_vld_ff;
   div_stage_type ent, prv, last;
   div_stage_type nxt_c [NST];
   div_stage_type div_ff [NST];
   logic [NST-1:0] dvld_ff;

   assign adv = !out_vld_ff || pop;
   assign q_pop = adv && q_port.valid;
   assign empty = !out_vld_ff;

   always_comb begin
      ent = '0;
      ent.rem_sa = (RWS'(q_port.item.color_a.d) << F) + RWS'(q_port.item.color_a.mx >> 1);
      ent.rem_sb = (RWS'(q_port.item.color_b.d) << F) + RWS'(q_port.item.color_b.mx >> 1);
      ent.rem_ha = (RWH'(q_port.item.color_a.h6) << F) + RWH'(q_port.item.color_a.d) * RWH'(3);
      ent.rem_hb = (RWH'(q_port.item.color_b.h6) << F) + RWH'(q_port.item.color_b.d) * RWH'(3);
      ent.mx_a = q_port.item.color_a.mx;
      ent.mx_b = q_port.item.color_b.mx;
      ent.d_a = q_port.item.color_a.d;
      ent.d_b = q_port.item.color_b.d;
      ent.t = q_port.item.t;
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         if (k == 0) begin
            prv = ent;
         end else begin
            prv = div_ff[k-1];
         end
         nxt_c[k] = div_step(prv, F - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else if (adv) begin
         dvld_ff <= {dvld_ff[NST-2:0], q_pop};
      end
      if (adv) begin
         for (int k = 0; k < NST; k++) begin
            div_ff[k] <= nxt_c[k];
         end
      end
   end

   assign last = div_ff[NST-1];

   // stage 1: special cases, value lookup, hue difference wrap
   logic p1_vld_ff;
   logic [F-1:0] p1_ha_ff, p1_ha_in;
   logic signed [F+1:0] p1_dh_ff, p1_dh_in;
   logic [F:0] p1_sa_ff, p1_sa_in, p1_sb_ff, p1_sb_in, p1_va_ff, p1_vb_ff;
   logic [8:0] p1_t_ff;
   logic [F-1:0] hb;

   always_comb begin
      p1_sa_in = (last.mx_a == '0) ? '0 : last.quo_sa;
      p1_sb_in = (last.mx_b == '0) ? '0 : last.quo_sb;
      p1_ha_in = (last.d_a == '0) ? '0 : last.quo_ha[F-1:0];
      hb = (last.d_b == '0) ? '0 : last.quo_hb[F-1:0];
      p1_dh_in = $signed({2'b00, hb}) - $signed({2'b00, p1_ha_in});
      if (p1_dh_in > HALF_S) begin
         p1_dh_in = p1_dh_in - ONE_S;
      end else if (p1_dh_in < -HALF_S) begin
         p1_dh_in = p1_dh_in + ONE_S;
      end
   end

   // stage 2: blend
   logic p2_vld_ff;
   logic [F-1:0] p2_h_ff;
   logic [F:0] p2_s_ff, p2_v_ff;
   logic signed [F+11:0] hprod, hacc;
   logic [F+9:0] ssum, vsum;
   logic [8:0] tc;

   always_comb begin
      tc = hci_pkg::BLEND_ONE - p1_t_ff;
      hprod = p1_dh_ff * $signed({1'b0, p1_t_ff});
      hacc = $signed({4'b0000, p1_ha_ff, 8'h00}) + hprod + (F+12)'(128);
      ssum = (F+10)'(p1_sa_ff) * (F+10)'(tc) + (F+10)'(p1_sb_ff) * (F+10)'(p1_t_ff)
             + (F+10)'(128);
      vsum = (F+10)'(p1_va_ff) * (F+10)'(tc) + (F+10)'(p1_vb_ff) * (F+10)'(p1_t_ff)
             + (F+10)'(128);
   end

   // stage 3: sector split, first products
   logic p3_vld_ff;
   logic [2:0] p3_sec_ff;
   logic [F:0] p3_v_ff, p3_p_ff, p3_fs_ff, p3_gs_ff;
   logic [F+2:0] x6;
   logic [F:0] fq;

   always_comb begin
      x6 = ((F+3)'(p2_h_ff) << 2) + ((F+3)'(p2_h_ff) << 1);
      fq = {1'b0, x6[F-1:0]};
   end

   // stage 4: second products
   logic p4_vld_ff;
   logic [2:0] p4_sec_ff;
   logic [F:0] p4_v_ff, p4_p_ff, p4_q_ff, p4_u_ff;

   // stage 5: channel select and byte conversion into the result register
   logic [F:0] cr, cg, cb;
   logic [7:0] red_ff, green_ff, blue_ff;

   always_comb begin
      case (hci_pkg::hci_sector_type'(p4_sec_ff))
         hci_pkg::SEC_RED_YEL: begin
            cr = p4_v_ff; cg = p4_u_ff; cb = p4_p_ff;
         end
         hci_pkg::SEC_YEL_GRN: begin
            cr = p4_q_ff; cg = p4_v_ff; cb = p4_p_ff;
         end
         hci_pkg::SEC_GRN_CYN: begin
            cr = p4_p_ff; cg = p4_v_ff; cb = p4_u_ff;
         end
         hci_pkg::SEC_CYN_BLU: begin
            cr = p4_p_ff; cg = p4_q_ff; cb = p4_v_ff;
         end
         hci_pkg::SEC_BLU_MAG: begin
            cr = p4_u_ff; cg = p4_p_ff; cb = p4_v_ff;
         end
         default: begin
            cr = p4_v_ff; cg = p4_p_ff; cb = p4_q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= dvld_ff[NST-1];
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         out_vld_ff <= p4_vld_ff;
      end
      if (adv) begin
         p1_ha_ff <= p1_ha_in;
         p1_dh_ff <= p1_dh_in;
         p1_sa_ff <= p1_sa_in;
         p1_sb_ff <= p1_sb_in;
         p1_va_ff <= vtab[last.mx_a];
         p1_vb_ff <= vtab[last.mx_b];
         p1_t_ff <= last.t;
         p2_h_ff <= hacc[F+7:8];
         p2_s_ff <= ssum[F+8:8];
         p2_v_ff <= vsum[F+8:8];
         p3_sec_ff <= x6[F+2:F];
         p3_v_ff <= p2_v_ff;
         p3_p_ff <= rnd_mul(p2_v_ff, ONE_Q - p2_s_ff);
         p3_fs_ff <= rnd_mul(fq, p2_s_ff);
         p3_gs_ff <= rnd_mul(ONE_Q - fq, p2_s_ff);
         p4_sec_ff <= p3_sec_ff;
         p4_v_ff <= p3_v_ff;
         p4_p_ff <= p3_p_ff;
         p4_q_ff <= rnd_mul(p3_v_ff, ONE_Q - p3_fs_ff);
         p4_u_ff <= rnd_mul(p3_v_ff, ONE_Q - p3_gs_ff);
         red_ff <= to_byte(cr);
         green_ff <= to_byte(cg);
         blue_ff <= to_byte(cb);
      end
   end

   assign rsp_out_red = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue = blue_ff;

endmodule

[rtl/hsv_color_interpolator_unit.sv]
// HSV colour interpolator top level: front end, queue and arithmetic back end.
//
// Input channel: push/full with the two RGB colours (req_from_*, req_to_*)
// and req_blend_amount (256 = 1.0, larger values act as 256). A transfer
// happens on a rising edge with push high and full low.
// Result channel: empty/pop with rsp_out_red/green/blue. The oldest result
// is on the ports while empty is low; a transfer happens with pop high.
// One result per input transfer, in order.
// The hue and saturation divisions take one pipeline stage per quotient bit,
// FRAC_BITS + 1 stages, followed by four arithmetic stages and the result
// register.
// Throughput: one transfer per cycle on each side while the receiver keeps popping results.
// Reset clears the queue and all valid flags; no item is held afterwards.
// While the receiver holds off pop with a result waiting, the back end
// freezes; the two-entry queue then fills and full rises.
module hsv_color_interpolator_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_from_red,
   input  logic [7:0] req_from_green,
   input  logic [7:0] req_from_blue,
   input  logic [7:0] req_to_red,
   input  logic [7:0] req_to_green,
   input  logic [7:0] req_to_blue,
   input  logic [8:0] req_blend_amount,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue
);

   hci_pkg::hci_item_type  fr_item;
   hci_pkg::hci_qport_type q_port;
   logic q_pop;

   hci_front u_front (
      .from_red     (req_from_red),
      .from_green   (req_from_green),
      .from_blue    (req_from_blue),
      .to_red       (req_to_red),
      .to_green     (req_to_green),
      .to_blue      (req_to_blue),
      .blend_amount (req_blend_amount),
      .item         (fr_item)
   );

   hci_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (fr_item),
      .full    (full),
      .pop     (q_pop),
      .rd_port (q_port)
   );

   hci_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_port        (q_port),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_port.valid)
      else $error("back end popped an empty queue");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(full && !q_port.valid))
      else $error("queue full and empty together");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(push && !full)) |-> q_port.valid)
      else $error("accepted transfer missing from queue");

endmodule
